// ===== src/crse_pkg.sv =====
// ----------------------------------------------------------------------------
// crse_pkg
// shared types, constants and helpers of the capture setup encoder
// ----------------------------------------------------------------------------
package crse_pkg;

    localparam int DIV_STAGES = 32;
    localparam int ENC_STAGES = 7;
    localparam int PIPE_DEPTH = 1 + DIV_STAGES + ENC_STAGES;

    localparam int IN_BYTES  = 9;
    localparam int OUT_BYTES = 11;

    localparam logic [31:0] RST_MAX_RATE = 32'd1000000000;
    localparam logic [31:0] RST_CPU_FREQ = 32'd50000000;
    localparam logic [15:0] RST_FAST_DIV = 16'd4;

    localparam logic [31:0] WIN_RATE_LOW  = 32'd250000000;
    localparam logic [31:0] WIN_RATE_MID  = 32'd500000000;
    localparam logic [31:0] WIN_RATE_HIGH = 32'd1000000000;

    localparam logic [1:0] WIN_HIGH  = 2'd1;
    localparam logic [1:0] WIN_MID   = 2'd2;
    localparam logic [1:0] WIN_OTHER = 2'd3;

    localparam logic [3:0] NIB_ONE   = 4'd1;
    localparam logic [3:0] NIB_EIGHT = 4'd8;
    localparam logic [3:0] NIB_TEN   = 4'd10;

    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    typedef enum logic [1:0] {
        CFG_MAX_RATE = 2'd0,
        CFG_CPU_FREQ = 2'd1,
        CFG_FAST_DIV = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SEL    = 2'd1,
        ST_BAD_LAYOUT = 2'd2,
        ST_ZERO_RATE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_FOUR = 2'd0,
        MODE_TWO  = 2'd1,
        MODE_ONE  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [31:0] sample_rate;
        logic [2:0]  channel_count;
        logic [4:0]  sample_bits;
        logic [5:0]  filter_first_bit;
        logic [5:0]  filter_end_bit;
        logic [3:0]  source_a;
        logic [3:0]  source_b;
        logic [3:0]  source_c;
        logic [3:0]  source_d;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic        fast_mode;
        logic [31:0] filter_word;
        t_mode       storage_mode;
        logic [2:0]  mux_0;
        logic [2:0]  mux_1;
        logic [2:0]  mux_2;
        logic [2:0]  mux_3;
    } t_meta;

    // floor(v / 10) by reciprocal, exact over 32 bits
    function automatic logic [31:0] f_div10(input logic [31:0] v);
        logic [63:0] p;
        p = 64'(v) * 64'(RECIP_TEN);
        return 32'(p >> 35);
    endfunction

    // nibble of a divide-by-ten stage
    function automatic logic [3:0] f_stage_nib(input logic [31:0] v);
        logic [3:0] n;
        if (v >= 32'd10) begin
            n = NIB_TEN;
        end else if (v == 32'd2 || v == 32'd4) begin
            n = v[3:0];
        end else begin
            n = NIB_ONE;
        end
        return n;
    endfunction

endpackage

// ===== src/capture_rate_and_channel_setup_encoder.sv =====
// ----------------------------------------------------------------------------
// capture_rate_and_channel_setup_encoder
// turns a capture setup request into rate code, filter word, storage mode
// and lane muxes
// ----------------------------------------------------------------------------
// Fully pipelined: one setup word is accepted every cycle while the output
// side takes words, and each result passes through forty register stages
// (one input stage, 32 divider stages for max_sample_rate / sample_rate,
// seven rate code encoder stages). A stall on the output freezes the whole
// pipeline. Configuration writes take effect for requests accepted afterwards.
module capture_rate_and_channel_setup_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_rate, channel_count, sample_bits, filter_first_bit,
    // filter_end_bit, source_a, source_b, source_c, source_d
    input  logic [crse_pkg::IN_BYTES*8-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, fast_mode, rate_code, rate_stage_fault, filter_word,
    // storage_mode, mux_0, mux_1, mux_2, mux_3
    output logic [crse_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);
    import crse_pkg::*;

    logic [31:0] r_max_rate;
    logic [31:0] r_cpu_freq;
    logic [15:0] r_fast_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate <= RST_MAX_RATE;
            r_cpu_freq <= RST_CPU_FREQ;
            r_fast_div <= RST_FAST_DIV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAX_RATE: r_max_rate <= i_cfg_data;
                CFG_CPU_FREQ: r_cpu_freq <= i_cfg_data;
                CFG_FAST_DIV: r_fast_div <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic                  w_en;
    logic                  w_accept;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign w_en          = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_accept};
        end
    end

    // input stage
    t_req        r_req;
    logic [31:0] r_max;
    logic [31:0] r_cpu;
    logic [15:0] r_div;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req <= t_req'({s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tdata[39:35],
                             s_axis_tdata[45:40], s_axis_tdata[51:46], s_axis_tdata[55:52],
                             s_axis_tdata[59:56], s_axis_tdata[63:60], s_axis_tdata[67:64]});
            r_max <= r_max_rate;
            r_cpu <= r_cpu_freq;
            r_div <= (r_fast_div == '0) ? 16'd1 : r_fast_div;
        end
    end

    // rate > cpu / div  <=>  rate * div > cpu
    logic [47:0] w_prod;
    logic        w_fast;
    logic        w_sel_bad;
    logic [31:0] w_mask;
    t_meta       w_meta;

    assign w_prod = 48'(r_req.sample_rate) * 48'(r_div);
    assign w_fast = w_prod > 48'(r_cpu);
    assign w_sel_bad = (r_req.source_a[3:2] != '0) || (r_req.source_b[3:2] != '0)
                    || (r_req.source_c[3:2] != '0) || (r_req.source_d[3:2] != '0);

    always_comb begin
        for (int b = 0; b < 32; b++) begin
            w_mask[b] = (6'(b) >= r_req.filter_first_bit) && (6'(b) < r_req.filter_end_bit);
        end
        if (r_req.filter_first_bit == '0 && r_req.filter_end_bit != '0) begin
            if (r_req.sample_rate == WIN_RATE_HIGH) begin
                w_mask[31:30] = w_mask[31:30] | WIN_HIGH;
            end else if (r_req.sample_rate == WIN_RATE_LOW
                         || r_req.sample_rate == WIN_RATE_MID) begin
                w_mask[31:30] = w_mask[31:30] | WIN_MID;
            end else begin
                w_mask[31:30] = WIN_OTHER;
            end
        end
    end

    always_comb begin
        logic [2:0] lo_a;
        logic [2:0] lo_b;
        logic [2:0] lo_c;
        logic [2:0] lo_d;
        lo_a = {1'b0, r_req.source_a[1:0]};
        lo_b = {1'b0, r_req.source_b[1:0]};
        lo_c = {1'b0, r_req.source_c[1:0]};
        lo_d = {1'b0, r_req.source_d[1:0]};
        w_meta = '0;
        w_meta.status = ST_OK;
        w_meta.storage_mode = MODE_FOUR;
        if (w_sel_bad) begin
            w_meta.status    = ST_BAD_SEL;
            w_meta.fast_mode = w_fast;
        end else if (r_req.sample_rate == '0) begin
            w_meta.status = ST_ZERO_RATE;
        end else begin
            w_meta.fast_mode   = w_fast;
            w_meta.filter_word = w_mask;
            if (r_req.sample_bits == 5'd8 && r_req.channel_count == 3'd1) begin
                w_meta.storage_mode = w_fast ? MODE_ONE : MODE_FOUR;
                w_meta.mux_0 = lo_a; w_meta.mux_1 = lo_a;
                w_meta.mux_2 = lo_a; w_meta.mux_3 = lo_a;
            end else if (r_req.sample_bits == 5'd8 && r_req.channel_count == 3'd2) begin
                w_meta.storage_mode = w_fast ? MODE_TWO : MODE_FOUR;
                w_meta.mux_0 = lo_a; w_meta.mux_1 = lo_b;
                w_meta.mux_2 = lo_a; w_meta.mux_3 = lo_b;
            end else if (r_req.sample_bits == 5'd8 && r_req.channel_count == 3'd4) begin
                w_meta.mux_0 = lo_a; w_meta.mux_1 = lo_b;
                w_meta.mux_2 = lo_c; w_meta.mux_3 = lo_d;
            end else if (r_req.sample_bits == 5'd16 && r_req.channel_count == 3'd1) begin
                w_meta.storage_mode = w_fast ? MODE_TWO : MODE_FOUR;
                w_meta.mux_0 = lo_a; w_meta.mux_1 = lo_a | 3'd4;
                w_meta.mux_2 = lo_a; w_meta.mux_3 = lo_a | 3'd4;
            end else if (r_req.sample_bits == 5'd16 && r_req.channel_count == 3'd2) begin
                w_meta.mux_0 = lo_a; w_meta.mux_1 = lo_a | 3'd4;
                w_meta.mux_2 = lo_b; w_meta.mux_3 = lo_b | 3'd4;
            end else begin
                w_meta.status = ST_BAD_LAYOUT;
            end
        end
    end

    // decimation divider with side fields alongside
    logic [31:0] w_quo;
    t_meta       r_meta [DIV_STAGES];

    crse_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_max),
        .i_den (r_req.sample_rate),
        .o_quo (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_meta[0] <= w_meta;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // rate code encoder, one nibble per stage
    logic [31:0] r_dec   [ENC_STAGES];
    logic [31:0] r_code  [ENC_STAGES];
    logic        r_fault [ENC_STAGES];
    t_meta       r_emeta [ENC_STAGES];

    logic [3:0]  w_nib0;
    logic [31:0] w_dec0;
    logic        w_fault0;

    always_comb begin
        w_fault0 = 1'b0;
        if (w_quo[2:0] == '0) begin
            w_nib0 = NIB_EIGHT;
            w_dec0 = w_quo >> 3;
        end else if (w_quo >= 32'd10) begin
            w_nib0 = NIB_TEN;
            w_dec0 = f_div10(w_quo);
        end else begin
            w_dec0 = '0;
            if (w_quo == 32'd1 || w_quo == 32'd2 || w_quo == 32'd4) begin
                w_nib0 = w_quo[3:0];
            end else begin
                w_nib0   = NIB_EIGHT;
                w_fault0 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dec[0]   <= w_dec0;
            r_code[0]  <= {28'd0, w_nib0};
            r_fault[0] <= w_fault0;
            r_emeta[0] <= r_meta[DIV_STAGES-1];
            for (int k = 1; k < ENC_STAGES; k++) begin
                r_dec[k]   <= f_div10(r_dec[k-1]);
                r_code[k]  <= r_code[k-1] | (32'(f_stage_nib(r_dec[k-1])) << (4 * k));
                r_fault[k] <= r_fault[k-1];
                r_emeta[k] <= r_emeta[k-1];
            end
        end
    end

    // output word
    t_meta       w_out;
    logic        w_kill;
    logic [31:0] w_code;
    logic        w_fault;

    assign w_out   = r_emeta[ENC_STAGES-1];
    assign w_kill  = (w_out.status == ST_BAD_SEL) || (w_out.status == ST_ZERO_RATE);
    assign w_code  = w_kill ? '0 : r_code[ENC_STAGES-1];
    assign w_fault = w_kill ? 1'b0 : r_fault[ENC_STAGES-1];

    assign m_axis_tdata = {6'd0, w_out.mux_3, w_out.mux_2, w_out.mux_1, w_out.mux_0,
                           w_out.storage_mode, w_out.filter_word, w_fault, w_code,
                           w_out.fast_mode, w_out.status};

    a_zero_rate_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_out.status == ST_ZERO_RATE |->
            !w_out.fast_mode && w_code == '0 && w_out.filter_word == '0)
        else $error("zero rate result not cleared");

    a_fault_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_fault |-> w_code[3:0] == NIB_EIGHT)
        else $error("stage fault without stage eight");

    a_layout_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_out.status != ST_OK |->
            w_out.storage_mode == MODE_FOUR && w_out.mux_0 == '0 && w_out.mux_3 == '0)
        else $error("failed request carries lane setup");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("pipeline valid after reset");

endmodule

// ===== src/crse_div.sv =====
// ----------------------------------------------------------------------------
// crse_div
// pipelined 32 bit restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module crse_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo
);
    import crse_pkg::*;

    logic [31:0] r_rem [DIV_STAGES];
    logic [31:0] r_num [DIV_STAGES];
    logic [31:0] r_den [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic [31:0] w_rem_in;
            logic [31:0] w_num_in;
            logic [31:0] w_den_in;
            logic [32:0] w_cand;
            logic        w_ge;
            logic [31:0] n_rem;

            if (k == 0) begin : g_first
                assign w_rem_in = '0;
                assign w_num_in = i_num;
                assign w_den_in = i_den;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_num_in = r_num[k-1];
                assign w_den_in = r_den[k-1];
            end

            always_comb begin
                w_cand = {w_rem_in, w_num_in[31]};
                w_ge   = w_cand >= {1'b0, w_den_in};
                n_rem  = w_ge ? 32'(w_cand - {1'b0, w_den_in}) : w_cand[31:0];
            end

            // quotient bits shift in from below as dividend bits leave
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_num[k] <= {w_num_in[30:0], w_ge};
                    r_den[k] <= w_den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_num[DIV_STAGES-1];

endmodule
